/* src/swnn_pkg.sv */
// ----------------------------------------------------------------------------
// swnn_pkg
// Shared types and constants for the sliding-window nearest-neighbor detector.
// ----------------------------------------------------------------------------
package swnn_pkg;

    localparam int WINDOW        = 64;
    localparam int DIM           = 16;
    localparam int MAX_RATES     = 4;
    localparam int NUM_RATE_REGS = 4;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DIM_W  = $clog2(DIM);
    localparam int ADDR_W = SLOT_W + DIM_W;
    localparam int DIST_W = 40;
    localparam int VAL_W  = 16;
    localparam int RATE_W = 16;
    localparam int NR_W   = 3;
    localparam int CIDX_W = 3;

    localparam logic [DIST_W-1:0] ALL_ONES = '1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_NUM_RATES = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_RATE_A    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RATE_B    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_RATE_C    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_RATE_D    = 3'd4;

    localparam logic [NR_W-1:0] NUM_RATES_RESET = 3'd1;
    localparam logic [RATE_W-1:0] RATE_RESET [NUM_RATE_REGS] =
        '{16'd3277, 16'd655, 16'd66, 16'd7};

    typedef struct packed {
        logic                    req_type;
        logic [3:0]              feature_index;
        logic signed [VAL_W-1:0] feature_value;
        logic                    last_element;
    } swnn_in_t;

    typedef struct packed {
        logic [2:0]        rate_bucket;
        logic [DIST_W-1:0] nearest_distance;
        logic              initialized;
    } swnn_out_t;

    typedef struct packed {
        logic              pend_wr;
        logic              pend_clr;
        logic              ref_from_pend;
        logic              dist_start;
        logic              dist_load;
        logic [SLOT_W-1:0] dist_slot;
        logic              st_we;
        logic [SLOT_W-1:0] st_slot;
        logic [DIM_W-1:0]  st_k;
        logic              nb_rd;
        logic [SLOT_W-1:0] nb_raddr;
        logic              nb_we;
        logic              nb_wsel_best;
        logic [SLOT_W-1:0] nb_waddr;
        logic [SLOT_W-1:0] nb_wslot;
        logic              best_init;
        logic              best_upd;
        logic [SLOT_W-1:0] best_slot;
        logic              th_latch;
        logic              th_cnt;
        logic              th_set;
        logic              out_load;
        logic              out_init;
    } swnn_cmd_t;

    typedef struct packed {
        logic              dist_done;
        logic              lt_nb;
        logic [SLOT_W-1:0] ns_rdata;
        logic              out_busy;
    } swnn_sts_t;

    // rank of the threshold in the sorted distances for one rate
    function automatic logic [SLOT_W-1:0] th_index(input logic [RATE_W-1:0] rate);
        localparam int PW = RATE_W + 1 + SLOT_W + 1;
        logic [RATE_W:0] comp;
        logic [PW-1:0]   prod;
        logic [PW-17:0]  q;
        comp = 17'h10000 - {1'b0, rate};
        prod = PW'(comp) * PW'(WINDOW);
        q    = prod[PW-1:16];
        if (int'(q) >= WINDOW) begin
            return SLOT_W'(WINDOW - 1);
        end
        return q[SLOT_W-1:0];
    endfunction

endpackage

/* src/swnn_dp.sv */
// ----------------------------------------------------------------------------
// swnn_dp
// Datapath: pending vector, vector store, distance pipe, neighbor tables,
// order-statistic thresholds, configuration and output register.
// ----------------------------------------------------------------------------
module swnn_dp
    import swnn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  swnn_in_t          in_data,
    input  logic              cfg_valid,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0] cfg_data,
    input  swnn_cmd_t         cmd,
    output swnn_sts_t         sts,
    output logic              out_valid,
    input  logic              out_ready,
    output swnn_out_t         out_data
);

    logic [VAL_W-1:0]  pend_reg [DIM];
    logic [VAL_W-1:0]  ref_reg  [DIM];
    logic [VAL_W-1:0]  store [WINDOW*DIM];
    logic [VAL_W-1:0]  st_rdata_reg;

    logic              issue_act_reg;
    logic [DIM_W-1:0]  issue_k_reg;
    logic [SLOT_W-1:0] issue_slot_reg;
    logic              load_reg;
    logic              p1_valid_reg, p1_last_reg;
    logic [DIM_W-1:0]  p1_k_reg;
    logic              p2_valid_reg, p2_last_reg;
    logic signed [VAL_W:0] diff_reg;
    logic              p3_valid_reg, p3_last_reg;
    logic [31:0]       sq_reg;
    logic [DIST_W-1:0] acc_reg;
    logic              done_reg;
    logic signed [2*VAL_W+1:0] prod;

    logic [DIST_W-1:0] nd_mem [WINDOW];
    logic [SLOT_W-1:0] ns_mem [WINDOW];
    logic              nv_reg [WINDOW];
    logic [DIST_W-1:0] nd_rdata_reg;
    logic [SLOT_W-1:0] ns_rdata_reg;

    logic [DIST_W-1:0] best_reg;
    logic [SLOT_W-1:0] best_slot_reg;

    logic [DIST_W-1:0] cand_reg;
    logic [CNT_W-1:0]  cnt_lt_reg, cnt_le_reg;
    logic              th_pend_reg;
    logic [DIST_W-1:0] thr_reg [MAX_RATES];

    logic [NR_W-1:0]   num_rates_reg;
    logic [RATE_W-1:0] rate_reg [NUM_RATE_REGS];

    logic              out_valid_reg;
    swnn_out_t         out_reg;
    logic [2:0]        bucket;
    logic [NR_W-1:0]   lim;
    logic              stop;

    // pending vector
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < DIM; i++) pend_reg[i] <= '0;
        end else if (cmd.pend_clr) begin
            for (int i = 0; i < DIM; i++) pend_reg[i] <= '0;
        end else if (cmd.pend_wr && int'(in_data.feature_index) < DIM) begin
            pend_reg[in_data.feature_index[DIM_W-1:0]] <= in_data.feature_value;
        end
    end

    // reference vector, loaded from pending or from a stored slot
    always_ff @(posedge clk) begin
        if (cmd.ref_from_pend) begin
            for (int i = 0; i < DIM; i++) ref_reg[i] <= pend_reg[i];
        end else if (p1_valid_reg && load_reg) begin
            ref_reg[p1_k_reg] <= st_rdata_reg;
        end
    end

    // vector store
    always_ff @(posedge clk) begin
        if (cmd.st_we) begin
            store[{cmd.st_slot, cmd.st_k}] <= pend_reg[cmd.st_k];
        end
        if (issue_act_reg) begin
            st_rdata_reg <= store[{issue_slot_reg, issue_k_reg}];
        end
    end

    // distance pipe: read, difference, square, accumulate
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            issue_act_reg <= 1'b0;
            issue_k_reg   <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            if (cmd.dist_start) begin
                issue_act_reg <= 1'b1;
                issue_k_reg   <= '0;
            end else if (issue_act_reg) begin
                issue_k_reg <= issue_k_reg + 1'b1;
                if (int'(issue_k_reg) == DIM - 1) issue_act_reg <= 1'b0;
            end
            p1_valid_reg <= issue_act_reg;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            done_reg     <= p3_valid_reg && p3_last_reg;
        end
    end

    assign prod = diff_reg * diff_reg;

    always_ff @(posedge clk) begin
        if (cmd.dist_start) begin
            issue_slot_reg <= cmd.dist_slot;
            load_reg       <= cmd.dist_load;
        end
        p1_k_reg    <= issue_k_reg;
        p1_last_reg <= (int'(issue_k_reg) == DIM - 1);
        diff_reg    <= $signed({st_rdata_reg[VAL_W-1], st_rdata_reg})
                     - $signed({ref_reg[p1_k_reg][VAL_W-1], ref_reg[p1_k_reg]});
        p2_last_reg <= p1_last_reg;
        sq_reg      <= prod[31:0];
        p3_last_reg <= p2_last_reg;
        if (cmd.dist_start) begin
            acc_reg <= '0;
        end else if (p3_valid_reg && !load_reg) begin
            acc_reg <= acc_reg + DIST_W'(sq_reg);
        end
    end

    // neighbor tables; an entry not yet written reads as all-ones distance and slot zero
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < WINDOW; i++) nv_reg[i] <= 1'b0;
        end else if (cmd.nb_we) begin
            nv_reg[cmd.nb_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.nb_we) begin
            nd_mem[cmd.nb_waddr] <= cmd.nb_wsel_best ? best_reg : acc_reg;
            ns_mem[cmd.nb_waddr] <= cmd.nb_wsel_best ? best_slot_reg : cmd.nb_wslot;
        end
        if (cmd.nb_rd) begin
            nd_rdata_reg <= nv_reg[cmd.nb_raddr] ? nd_mem[cmd.nb_raddr] : ALL_ONES;
            ns_rdata_reg <= nv_reg[cmd.nb_raddr] ? ns_mem[cmd.nb_raddr] : '0;
        end
    end

    // running nearest
    always_ff @(posedge clk) begin
        if (cmd.best_init) begin
            best_reg      <= ALL_ONES;
            best_slot_reg <= cmd.best_slot;
        end else if (cmd.best_upd && acc_reg < best_reg) begin
            best_reg      <= acc_reg;
            best_slot_reg <= cmd.best_slot;
        end
    end

    // order statistics: rank of one candidate against all entries
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            th_pend_reg <= 1'b0;
            for (int r = 0; r < MAX_RATES; r++) thr_reg[r] <= '0;
        end else begin
            th_pend_reg <= cmd.th_cnt;
            if (cmd.th_set) begin
                for (int r = 0; r < MAX_RATES; r++) begin
                    if (cnt_lt_reg <= CNT_W'(th_index(rate_reg[r]))
                        && CNT_W'(th_index(rate_reg[r])) < cnt_le_reg) begin
                        thr_reg[r] <= cand_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.th_latch) begin
            cand_reg   <= nd_rdata_reg;
            cnt_lt_reg <= '0;
            cnt_le_reg <= '0;
        end else if (th_pend_reg) begin
            if (nd_rdata_reg < cand_reg) cnt_lt_reg <= cnt_lt_reg + 1'b1;
            if (nd_rdata_reg <= cand_reg) cnt_le_reg <= cnt_le_reg + 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            num_rates_reg <= NUM_RATES_RESET;
            for (int r = 0; r < NUM_RATE_REGS; r++) rate_reg[r] <= RATE_RESET[r];
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_NUM_RATES: num_rates_reg <= cfg_data[NR_W-1:0];
                CFG_RATE_A:    rate_reg[0] <= cfg_data;
                CFG_RATE_B:    rate_reg[1] <= cfg_data;
                CFG_RATE_C:    rate_reg[2] <= cfg_data;
                CFG_RATE_D:    rate_reg[3] <= cfg_data;
                default:       ;
            endcase
        end
    end

    // bucket: thresholds exceeded in order
    always_comb begin
        lim    = (int'(num_rates_reg) > MAX_RATES) ? NR_W'(MAX_RATES) : num_rates_reg;
        bucket = '0;
        stop   = 1'b0;
        for (int r = 0; r < MAX_RATES; r++) begin
            if (!stop && NR_W'(r) < lim && best_reg > thr_reg[r]) begin
                bucket = bucket + 1'b1;
            end else begin
                stop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            out_reg.rate_bucket      <= cmd.out_init ? bucket : 3'd0;
            out_reg.nearest_distance <= best_reg;
            out_reg.initialized      <= cmd.out_init;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;
    assign sts.dist_done = done_reg;
    assign sts.lt_nb     = acc_reg < nd_rdata_reg;
    assign sts.ns_rdata  = ns_rdata_reg;
    assign sts.out_busy  = out_valid_reg && !out_ready;

endmodule

/* src/swnn_ctrl.sv */
// ----------------------------------------------------------------------------
// swnn_ctrl
// Controller: element intake, fit/predict sequencing, neighbor searches,
// recheck scan and threshold ranking.
// ----------------------------------------------------------------------------
module swnn_ctrl
    import swnn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  swnn_in_t  in_data,
    input  swnn_sts_t sts,
    output swnn_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_F_WR, S_S_INIT, S_S_NEXT, S_S_WAIT, S_S_END,
        S_R_SCAN, S_R_DRAIN, S_R_NEXT, S_R_LOAD,
        S_T_CAND, S_T_LATCH, S_T_SCAN, S_T_DRAIN, S_T_SET,
        S_P_START, S_P_OUT, S_DONE
    } state_t;

    typedef enum logic [1:0] {PH_FILL, PH_RECHK, PH_NEW} phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    logic              pred_reg;
    logic [CNT_W-1:0]  fill_reg, n_reg, m_reg, count_reg;
    logic [SLOT_W-1:0] oldest_reg, col_reg, skip_reg, i_reg, j_reg, rd_n_reg;
    logic              skip_en_reg, rd_pend_reg;
    logic [DIM_W-1:0]  k_reg;
    logic              rc_reg [WINDOW];
    logic              skip_n;

    assign in_ready = (state_reg == S_IDLE);
    assign skip_n   = !pred_reg && (n_reg[SLOT_W-1:0] == col_reg
                      || (skip_en_reg && n_reg[SLOT_W-1:0] == skip_reg));

    always_comb begin
        cmd              = '0;
        cmd.pend_wr      = in_valid && in_ready;
        cmd.dist_slot    = n_reg[SLOT_W-1:0];
        cmd.st_slot      = col_reg;
        cmd.st_k         = k_reg;
        cmd.nb_raddr     = n_reg[SLOT_W-1:0];
        cmd.nb_waddr     = n_reg[SLOT_W-1:0];
        cmd.nb_wslot     = col_reg;
        cmd.best_slot    = n_reg[SLOT_W-1:0];
        cmd.out_init     = (int'(fill_reg) == WINDOW);
        case (state_reg)
            S_F_WR: begin
                cmd.st_we         = 1'b1;
                cmd.ref_from_pend = 1'b1;
            end
            S_S_INIT: begin
                cmd.best_init = 1'b1;
                cmd.best_slot = col_reg;
            end
            S_S_NEXT: begin
                if (n_reg != count_reg && !skip_n) begin
                    cmd.dist_start = 1'b1;
                    cmd.nb_rd      = 1'b1;
                end
            end
            S_S_WAIT: begin
                if (sts.dist_done) begin
                    cmd.best_upd = 1'b1;
                    cmd.nb_we    = !pred_reg && sts.lt_nb;
                end
            end
            S_S_END: begin
                if (!pred_reg) begin
                    cmd.nb_we        = 1'b1;
                    cmd.nb_wsel_best = 1'b1;
                    cmd.nb_waddr     = col_reg;
                end
            end
            S_R_SCAN: cmd.nb_rd = 1'b1;
            S_R_NEXT: begin
                cmd.dist_slot = m_reg[SLOT_W-1:0];
                cmd.dist_load = 1'b1;
                cmd.dist_start = (int'(m_reg) != WINDOW) && rc_reg[m_reg[SLOT_W-1:0]];
            end
            S_T_CAND: begin
                cmd.nb_rd    = 1'b1;
                cmd.nb_raddr = i_reg;
            end
            S_T_LATCH: cmd.th_latch = 1'b1;
            S_T_SCAN: begin
                cmd.nb_rd    = 1'b1;
                cmd.nb_raddr = j_reg;
                cmd.th_cnt   = 1'b1;
            end
            S_T_SET:   cmd.th_set = 1'b1;
            S_P_START: cmd.ref_from_pend = 1'b1;
            S_P_OUT:   cmd.out_load = !sts.out_busy;
            S_DONE:    cmd.pend_clr = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_FILL;
            pred_reg    <= 1'b0;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            n_reg       <= '0;
            m_reg       <= '0;
            count_reg   <= '0;
            col_reg     <= '0;
            skip_reg    <= '0;
            skip_en_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            rd_n_reg    <= '0;
            rd_pend_reg <= 1'b0;
            for (int i = 0; i < WINDOW; i++) rc_reg[i] <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == S_R_SCAN);
            rd_n_reg    <= n_reg[SLOT_W-1:0];
            if (rd_pend_reg) begin
                rc_reg[rd_n_reg] <= (sts.ns_rdata == oldest_reg) && (rd_n_reg != oldest_reg);
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_data.last_element) begin
                        if (in_data.req_type) begin
                            pred_reg  <= 1'b1;
                            state_reg <= S_P_START;
                        end else if (int'(fill_reg) < WINDOW) begin
                            col_reg     <= fill_reg[SLOT_W-1:0];
                            skip_en_reg <= 1'b0;
                            count_reg   <= fill_reg + 1'b1;
                            phase_reg   <= PH_FILL;
                            k_reg       <= '0;
                            state_reg   <= S_F_WR;
                        end else begin
                            n_reg     <= '0;
                            state_reg <= S_R_SCAN;
                        end
                    end
                end
                S_F_WR: begin
                    k_reg <= k_reg + 1'b1;
                    if (int'(k_reg) == DIM - 1) state_reg <= S_S_INIT;
                end
                S_S_INIT: begin
                    n_reg     <= '0;
                    state_reg <= S_S_NEXT;
                end
                S_S_NEXT: begin
                    if (n_reg == count_reg) begin
                        state_reg <= S_S_END;
                    end else if (skip_n) begin
                        n_reg <= n_reg + 1'b1;
                    end else begin
                        state_reg <= S_S_WAIT;
                    end
                end
                S_S_WAIT: begin
                    if (sts.dist_done) begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_S_NEXT;
                    end
                end
                S_S_END: begin
                    if (pred_reg) begin
                        state_reg <= S_P_OUT;
                    end else begin
                        case (phase_reg)
                            PH_FILL: begin
                                fill_reg <= fill_reg + 1'b1;
                                i_reg    <= '0;
                                state_reg <= (int'(fill_reg) == WINDOW - 1) ? S_T_CAND
                                                                            : S_DONE;
                            end
                            PH_RECHK: begin
                                m_reg     <= m_reg + 1'b1;
                                state_reg <= S_R_NEXT;
                            end
                            default: begin
                                i_reg     <= '0;
                                state_reg <= S_T_CAND;
                            end
                        endcase
                    end
                end
                S_R_SCAN: begin
                    n_reg <= n_reg + 1'b1;
                    if (int'(n_reg) == WINDOW - 1) state_reg <= S_R_DRAIN;
                end
                S_R_DRAIN: begin
                    m_reg     <= '0;
                    state_reg <= S_R_NEXT;
                end
                S_R_NEXT: begin
                    if (int'(m_reg) == WINDOW) begin
                        col_reg     <= oldest_reg;
                        skip_en_reg <= 1'b0;
                        count_reg   <= CNT_W'(WINDOW);
                        phase_reg   <= PH_NEW;
                        k_reg       <= '0;
                        state_reg   <= S_F_WR;
                    end else if (rc_reg[m_reg[SLOT_W-1:0]]) begin
                        state_reg <= S_R_LOAD;
                    end else begin
                        m_reg <= m_reg + 1'b1;
                    end
                end
                S_R_LOAD: begin
                    if (sts.dist_done) begin
                        col_reg     <= m_reg[SLOT_W-1:0];
                        skip_reg    <= oldest_reg;
                        skip_en_reg <= 1'b1;
                        count_reg   <= CNT_W'(WINDOW);
                        phase_reg   <= PH_RECHK;
                        state_reg   <= S_S_INIT;
                    end
                end
                S_T_CAND:  state_reg <= S_T_LATCH;
                S_T_LATCH: begin
                    j_reg     <= '0;
                    state_reg <= S_T_SCAN;
                end
                S_T_SCAN: begin
                    j_reg <= j_reg + 1'b1;
                    if (int'(j_reg) == WINDOW - 1) state_reg <= S_T_DRAIN;
                end
                S_T_DRAIN: state_reg <= S_T_SET;
                S_T_SET: begin
                    i_reg <= i_reg + 1'b1;
                    if (int'(i_reg) == WINDOW - 1) begin
                        if (phase_reg == PH_NEW) begin
                            oldest_reg <= (int'(oldest_reg) == WINDOW - 1) ? '0
                                        : oldest_reg + 1'b1;
                        end
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_T_CAND;
                    end
                end
                S_P_START: begin
                    count_reg   <= fill_reg;
                    skip_en_reg <= 1'b0;
                    state_reg   <= S_S_INIT;
                end
                S_P_OUT: begin
                    if (!sts.out_busy) state_reg <= S_DONE;
                end
                S_DONE: begin
                    pred_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a distance completes only while something waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.dist_done |-> (state_reg == S_S_WAIT || state_reg == S_R_LOAD))
        else $error("distance done outside a wait state");

    // predict never writes the neighbor tables
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.nb_we |-> !pred_reg)
        else $error("neighbor write during predict");

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= WINDOW)
        else $error("fill count beyond window");

    // result loaded only for a predict
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> pred_reg)
        else $error("result without predict");

endmodule

/* src/sliding_window_nn_anomaly_detector.sv */
// ----------------------------------------------------------------------------
// sliding_window_nn_anomaly_detector
// Nearest-neighbor anomaly scoring over a sliding window of feature vectors.
// ----------------------------------------------------------------------------
// channel  direction  handshake                payload
// in       input      in_valid / in_ready      in_data  (swnn_in_t)
// out      output     out_valid / out_ready    out_data (swnn_out_t)
// cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A non-last element is written to the pending vector and in_ready stays high.
// A completed vector is processed one element per cycle through the distance
// pipe: a predict searches every stored slot; a fit runs one neighbor search
// per orphaned entry, each after a reload of that entry, plus one for the new
// vector, then ranks thresholds once the window is full. in_ready is low while
// a vector is processed and while a result waits for the output register.
// cfg_ready is always high. Reset clears control state, the pending vector,
// valid bits, thresholds and config; the vector store and other data are not.
// ----------------------------------------------------------------------------
module sliding_window_nn_anomaly_detector
    import swnn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  swnn_in_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output swnn_out_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0] cfg_data
);

    swnn_cmd_t cmd;
    swnn_sts_t sts;

    assign cfg_ready = 1'b1;

    swnn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .sts      (sts),
        .cmd      (cmd)
    );

    swnn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
